[hw/rtl/mie_pkg.sv]
`default_nettype none

package mie_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int DEF_WORD_BITS = 32;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] modulus;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_BITS-1:0] inverse;
        logic                  not_invertible;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[hw/rtl/modular_inverse_ext_euclid.sv]
// channel  direction  handshake            word
// input    in         i_valid / o_ready    i_word  (value, modulus)
// output   out        o_valid / i_ready    o_word  (inverse, not_invertible)
//
// one word at a time; o_ready is high only while the sequencer is idle
// each euclid step is one pass through the bit-serial divide unit
// a finished result waits in the output register; the next word is taken meanwhile
// a stalled output holds the sequencer in its last state until the register frees
// i_rst_n is synchronous, active low, and clears the control state only
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output      logic      o_ready,
    input  wire t_in_word  i_word,
    output      logic      o_valid,
    input  wire logic      i_ready,
    output      t_out_word o_word
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           r_state;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_prev;
    logic [WORD_BITS-1:0] r_cur;
    logic                 r_odd;
    logic [WORD_BITS-1:0] r_res;
    logic                 r_err;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 w_start;
    logic [WORD_BITS-1:0] w_rem;
    logic [WORD_BITS-1:0] w_prod;
    t_div_stat            w_stat;

    assign w_start = (r_state == ST_CHECK) && (r_mod != WORD_BITS'(1))
                     && (r_a > WORD_BITS'(1)) && (r_b != '0);

    mie_divmul #(
        .WORD_BITS (WORD_BITS)
    ) u_divmul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .i_mcand    (r_cur),
        .o_rem      (w_rem),
        .o_prod     (w_prod),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (w_start) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (w_stat.done) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_a    <= WORD_BITS'(i_word.value);
                    r_b    <= WORD_BITS'(i_word.modulus);
                    r_mod  <= WORD_BITS'(i_word.modulus);
                    r_prev <= WORD_BITS'(1);
                    r_cur  <= '0;
                    r_odd  <= 1'b0;
                end
            end
            ST_CHECK: begin
                priority if (r_mod == WORD_BITS'(1)) begin
                    r_res <= WORD_BITS'(1);
                    r_err <= 1'b0;
                end else if (r_a > WORD_BITS'(1)) begin
                    r_res <= '0;
                    r_err <= 1'b1;
                end else begin
                    // negative coefficient after an odd step count
                    r_res <= (r_odd && r_prev != '0) ? (r_mod - r_prev) : r_prev;
                    r_err <= 1'b0;
                end
            end
            ST_DIV: begin
                if (w_stat.done) begin
                    r_a    <= r_b;
                    r_b    <= w_rem;
                    r_prev <= r_cur;
                    r_cur  <= r_prev + w_prod;
                    r_odd  <= !r_odd;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_out_word <= '{inverse: FIELD_BITS'(r_res), not_invertible: r_err};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

`ifndef NO_ASSERTIONS
    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.busy)
        else $error("divide unit busy while idle");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_DIV))
        else $error("divide done outside divide state");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.not_invertible) |-> (o_word.inverse == '0))
        else $error("flagged word carries a nonzero inverse");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while one is in work");
`endif

endmodule

`default_nettype wire

[hw/rtl/mie_divmul.sv]
`default_nettype none

module mie_divmul
    import mie_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_dividend,
    input  wire logic [WORD_BITS-1:0] i_divisor,
    input  wire logic [WORD_BITS-1:0] i_mcand,
    output      logic [WORD_BITS-1:0] o_rem,
    output      logic [WORD_BITS-1:0] o_prod,
    output      t_div_stat            o_stat
);

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_acc;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [WORD_BITS:0]   w_shift;
    logic [WORD_BITS+1:0] w_diff;
    logic                 w_qbit;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_acc;

    // one quotient bit a cycle, folded straight into quotient times multiplicand
    always_comb begin
        w_shift = {r_rem, r_dvd[WORD_BITS-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, i_divisor};
        w_qbit  = !w_diff[WORD_BITS+1];
        n_rem   = w_qbit ? w_diff[WORD_BITS-1:0] : w_shift[WORD_BITS-1:0];
        n_acc   = {r_acc[WORD_BITS-2:0], 1'b0} + (w_qbit ? i_mcand : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= CNT_BITS'(WORD_BITS - 1);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WORD_BITS-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    assign o_rem       = r_rem;
    assign o_prod      = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire
